### rtl/core/peval_pkg.sv
// ---------------------------------------------------------------------------
// peval_pkg
// Shared types and constants of the polynomial evaluator: data width,
// microcode step codes, jump conditions, control word layout and the
// microcode program itself.
// ---------------------------------------------------------------------------
package peval_pkg;

   // data path word width, signed fixed point
   localparam int unsigned WORD_W = 32;
   // width of the externally visible degree and power fields
   localparam int unsigned FIELD_W = 4;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // microcode step address
   localparam int unsigned STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_LOAD = 3'd1;
   localparam step_type STEP_MUL  = 3'd2;
   localparam step_type STEP_ADD  = 3'd3;
   localparam step_type STEP_DONE = 3'd4;

   // jump conditions: true selects target_t, false selects target_f
   typedef enum logic [1:0] {
      JC_NONE,
      JC_NO_EVAL,
      JC_K_ZERO,
      JC_OUT_BUSY
   } jcond_type;

   // one control word of the program
   typedef struct packed {
      jcond_type cond;
      step_type  target_t;
      step_type  target_f;
      logic      take_req;   // input channel open in this step
      logic      start;      // capture x, clear flag, read top coefficient
      logic      acc_load;   // accumulator takes memory read data
      logic      k_step;     // count k down and read coefficient k-1
      logic      mul_en;     // product register takes acc * x
      logic      add_en;     // accumulator takes sat(sat(prod) + coef)
      logic      out_load;   // result register takes the accumulator
   } uword_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic start;
      logic acc_load;
      logic mul_en;
      logic add_en;
      logic out_load;
   } ctrl_type;

   // microcode program
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '0;
      w.cond     = JC_NONE;
      w.target_t = STEP_IDLE;
      w.target_f = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.cond     = JC_NO_EVAL;
            w.target_t = STEP_IDLE;
            w.target_f = STEP_LOAD;
            w.take_req = 1'b1;
            w.start    = 1'b1;
         end
         STEP_LOAD: begin
            w.cond     = JC_K_ZERO;
            w.target_t = STEP_DONE;
            w.target_f = STEP_MUL;
            w.acc_load = 1'b1;
            w.k_step   = 1'b1;
         end
         STEP_MUL: begin
            w.cond     = JC_NONE;
            w.target_f = STEP_ADD;
            w.mul_en   = 1'b1;
         end
         STEP_ADD: begin
            w.cond     = JC_K_ZERO;
            w.target_t = STEP_DONE;
            w.target_f = STEP_MUL;
            w.add_en   = 1'b1;
            w.k_step   = 1'b1;
         end
         STEP_DONE: begin
            w.cond     = JC_OUT_BUSY;
            w.target_t = STEP_DONE;
            w.target_f = STEP_IDLE;
            w.out_load = 1'b1;
         end
         default: begin
            w.cond     = JC_NONE;
            w.target_f = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/core/peval_coef_mem.sv
// ---------------------------------------------------------------------------
// peval_coef_mem
// Coefficient memory: one write port, one registered read port. Per-entry
// valid bits make never-written entries read as zero after reset.
// ---------------------------------------------------------------------------
module peval_coef_mem #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [ADDR_W-1:0]                    wr_addr,
   input  logic signed [peval_pkg::WORD_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [ADDR_W-1:0]                    rd_addr,
   output logic signed [peval_pkg::WORD_W-1:0]  rd_data
);

   logic signed [peval_pkg::WORD_W-1:0] coef_mem_ff [DEPTH];
   logic [DEPTH-1:0]                    valid_ff;
   logic signed [peval_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem_ff[wr_addr] <= wr_data;
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? coef_mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/peval_datapath.sv
// ---------------------------------------------------------------------------
// peval_datapath
// Horner datapath: x register, accumulator, registered 32x32 product,
// floor shift with saturation, saturating add, sticky flag and the
// result register of the output channel.
// ---------------------------------------------------------------------------
module peval_datapath #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  peval_pkg::ctrl_type                  ctrl,
   input  logic signed [peval_pkg::WORD_W-1:0]  x_value,
   input  logic signed [peval_pkg::WORD_W-1:0]  coef,
   output logic                                 out_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [peval_pkg::WORD_W-1:0]  rsp_poly_value,
   output logic                                 rsp_saturated
);

   localparam int unsigned W  = peval_pkg::WORD_W;
   localparam int unsigned PW = 2 * W;

   logic signed [W-1:0]  x_ff;
   logic signed [W-1:0]  acc_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 flag_ff;
   logic signed [W-1:0]  rsp_poly_value_ff;
   logic                 rsp_saturated_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   logic signed [PW-1:0] shifted;
   logic                 prod_ovf;
   logic signed [W-1:0]  prod_sat;
   logic signed [W:0]    sum;
   logic                 sum_ovf;
   logic signed [W-1:0]  sum_sat;

   // floor shift of the product and saturation to the word range
   always_comb begin
      shifted  = prod_ff >>> FRAC_BITS;
      prod_ovf = (shifted[PW-1:W-1] != '0) && (shifted[PW-1:W-1] != '1);
      if (!prod_ovf) begin
         prod_sat = shifted[W-1:0];
      end else if (shifted[PW-1]) begin
         prod_sat = {1'b1, {(W-1){1'b0}}};
      end else begin
         prod_sat = {1'b0, {(W-1){1'b1}}};
      end
   end

   // saturating add of the next coefficient
   always_comb begin
      sum     = {prod_sat[W-1], prod_sat} + {coef[W-1], coef};
      sum_ovf = sum[W] != sum[W-1];
      if (!sum_ovf) begin
         sum_sat = sum[W-1:0];
      end else if (sum[W]) begin
         sum_sat = {1'b1, {(W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(W-1){1'b1}}};
      end
   end

   // operand and accumulator registers
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff <= x_value;
      end
      if (ctrl.mul_en) begin
         prod_ff <= PW'(acc_ff) * PW'(x_ff);
      end
      if (ctrl.acc_load) begin
         acc_ff <= coef;
      end else if (ctrl.add_en) begin
         acc_ff <= sum_sat;
      end
   end

   // sticky saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (ctrl.start) begin
         flag_ff <= 1'b0;
      end else if (ctrl.add_en && (prod_ovf || sum_ovf)) begin
         flag_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_poly_value_ff <= acc_ff;
         rsp_saturated_ff  <= flag_ff;
      end
   end

   // result valid: set on load, cleared after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_busy       = rsp_valid_ff && rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_poly_value = rsp_poly_value_ff;
   assign rsp_saturated  = rsp_saturated_ff;

endmodule

### rtl/core/peval_sequencer.sv
// ---------------------------------------------------------------------------
// peval_sequencer
// Microcode sequencer: step counter into the program ROM, conditional
// jumps, coefficient index counter and memory read address.
// ---------------------------------------------------------------------------
module peval_sequencer #(
   parameter int unsigned ADDR_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   input  logic [ADDR_W-1:0]    degree,
   input  logic                 out_busy,
   output logic                 req_stall,
   output peval_pkg::ctrl_type  ctrl,
   output logic                 rd_en,
   output logic [ADDR_W-1:0]    rd_addr
);

   peval_pkg::step_type  step_ff;
   peval_pkg::step_type  step_in;
   peval_pkg::uword_type uword;
   logic [ADDR_W-1:0]    k_ff;
   logic [ADDR_W-1:0]    k_in;
   logic                 k_zero;
   logic                 cond_true;

   assign uword  = peval_pkg::ucode_rom(step_ff);
   assign k_zero = (k_ff == '0);

   // jump condition and next step
   always_comb begin
      unique case (uword.cond)
         peval_pkg::JC_NONE:     cond_true = 1'b0;
         peval_pkg::JC_NO_EVAL:  cond_true = !(req_valid && (req_op == peval_pkg::OP_EVAL));
         peval_pkg::JC_K_ZERO:   cond_true = k_zero;
         peval_pkg::JC_OUT_BUSY: cond_true = out_busy;
         default:                cond_true = 1'b0;
      endcase
      step_in = cond_true ? uword.target_t : uword.target_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= peval_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // coefficient index and memory read request
   always_comb begin
      k_in    = k_ff;
      rd_en   = 1'b0;
      rd_addr = k_ff - 1'b1;
      if (uword.start) begin
         k_in    = degree;
         rd_en   = 1'b1;
         rd_addr = degree;
      end else if (uword.k_step && !k_zero) begin
         k_in  = k_ff - 1'b1;
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   // datapath control
   always_comb begin
      ctrl.start    = uword.start;
      ctrl.acc_load = uword.acc_load;
      ctrl.mul_en   = uword.mul_en;
      ctrl.add_en   = uword.add_en;
      ctrl.out_load = uword.out_load && !out_busy;
   end

   assign req_stall = !uword.take_req;

endmodule

### rtl/core/polynomial_evaluator_core.sv
// ---------------------------------------------------------------------------
// polynomial_evaluator_core
// Horner polynomial evaluator in signed fixed point with a coefficient
// memory, driven by a microcoded sequencer.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | op, coef_power, coef_value, x_value
//   rsp     | out       | rsp_valid/rsp_stall | poly_value, saturated
//   csr     | in        | csr_valid/csr_ready | poly_degree
//
// A load item is written without leaving the idle step. An evaluate item
// of degree d runs LOAD, then a MUL and an ADD step per further
// coefficient, as the multiply then add around the accumulator are
// dependent, and then DONE. Reset is synchronous and clears the coefficients to zero
// through per-entry valid bits, with no clearing pass. The finished
// result waits in an output register; a stalled result holds the
// sequencer only when the next result is ready to be written.
// ---------------------------------------------------------------------------
module polynomial_evaluator_core #(
   parameter int unsigned MAX_DEGREE = 15,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_op,
   input  logic [peval_pkg::FIELD_W-1:0]           req_coef_power,
   input  logic signed [peval_pkg::WORD_W-1:0]     req_coef_value,
   input  logic signed [peval_pkg::WORD_W-1:0]     req_x_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [peval_pkg::WORD_W-1:0]     rsp_poly_value,
   output logic                                    rsp_saturated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [peval_pkg::FIELD_W-1:0]           csr_poly_degree
);

   localparam int unsigned DEPTH  = MAX_DEGREE + 1;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CMP_W  = (ADDR_W > peval_pkg::FIELD_W) ?
                                    ADDR_W : peval_pkg::FIELD_W;

   logic [peval_pkg::FIELD_W-1:0]       poly_degree_ff;
   logic [CMP_W-1:0]                    degree_ext;
   logic [CMP_W-1:0]                    power_ext;
   logic [CMP_W-1:0]                    degree_clamped;
   logic [ADDR_W-1:0]                   degree;
   logic                                wr_en;
   logic [ADDR_W-1:0]                   wr_addr;
   logic                                rd_en;
   logic [ADDR_W-1:0]                   rd_addr;
   logic signed [peval_pkg::WORD_W-1:0] rd_data;
   logic                                out_busy;
   peval_pkg::ctrl_type                 ctrl;

   // degree register, written by csr transfers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_degree_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         poly_degree_ff <= csr_poly_degree;
      end
   end

   // degree clamped to the table
   always_comb begin
      degree_ext     = CMP_W'(poly_degree_ff);
      degree_clamped = (degree_ext > CMP_W'(MAX_DEGREE)) ? CMP_W'(MAX_DEGREE) : degree_ext;
      degree         = degree_clamped[ADDR_W-1:0];
   end

   // coefficient write on a load transfer inside the table
   always_comb begin
      power_ext = CMP_W'(req_coef_power);
      wr_addr   = power_ext[ADDR_W-1:0];
      wr_en     = req_valid && !req_stall && (req_op == peval_pkg::OP_LOAD) &&
                  (power_ext <= CMP_W'(MAX_DEGREE));
   end

   peval_coef_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_coef_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   peval_sequencer #(
      .ADDR_W (ADDR_W)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .degree    (degree),
      .out_busy  (out_busy),
      .req_stall (req_stall),
      .ctrl      (ctrl),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   peval_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .x_value        (req_x_value),
      .coef           (rd_data),
      .out_busy       (out_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_poly_value (rsp_poly_value),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
